// File: hdl/reh_pkg.sv
`timescale 1ns / 1ps

package reh_pkg;

	typedef logic [23:0] pixel_t;

	typedef enum logic [1:0] {
		MODE_GRAY       = 2'd0,
		MODE_EDGE_ORIG  = 2'd1,
		MODE_GRAD_BG    = 2'd2,
		MODE_EDGE_BG    = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_THRESHOLD    = 3'd2,
		REG_MODE         = 3'd3,
		REG_EDGE_COLOR   = 3'd4,
		REG_BG_COLOR     = 3'd5
	} reg_index_t;

	// which of the up to four results of one pixel is being sent
	typedef enum logic [1:0] {
		RES_DIAG     = 2'd0,
		RES_LAST_COL = 2'd1,
		RES_LAST_ROW = 2'd2,
		RES_CORNER   = 2'd3
	} res_sel_t;

	function automatic logic [9:0] absdiff3(input pixel_t a, input pixel_t b);
		logic [7:0] x;
		logic [7:0] y;
		logic [9:0] s;
		s = '0;
		for (int i = 0; i < 3; i++) begin
			x = a[8*i +: 8];
			y = b[8*i +: 8];
			s = s + ((x > y) ? 10'(x - y) : 10'(y - x));
		end
		return s;
	endfunction

	function automatic logic [10:0] roberts(input pixel_t p00, input pixel_t p01,
			input pixel_t p10, input pixel_t p11);
		return 11'(absdiff3(p00, p11)) + 11'(absdiff3(p10, p01));
	endfunction

endpackage

// File: hdl/roberts_edge_highlighter_core.sv
`timescale 1ns / 1ps

// channel   dir  handshake              payload
// s_axis    in   tvalid/tready          tdata: ch0, ch1, ch2
// m_axis    out  tvalid/tready, tlast   tdata: row, col, ch0, ch1, ch2; tlast: last of pixel
// cfg       in   we (no wait)           index, data
//
// one pixel per clock while m_axis is ready, save that a pixel in the last column below the top
// row or in the last row past its first column has two results and the last pixel of the frame
// four, which leave one per clock through the output register while s_axis is held. the line
// store read happens as a pixel is taken, the gradient is formed in the next stage and lands
// in the output register.
// reset clears counters, neighbor pixels, configuration registers and valid flags; the line store is not cleared.
// a stalled m_axis holds the sequencing stage, which then holds s_axis.

module roberts_edge_highlighter_core
	import reh_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // ch0 [7:0], ch1 [15:8], ch2 [23:16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // row [9:0], col [19:10], ch0, ch1, ch2, zero pad
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	// configuration
	logic [10:0] image_width_q;
	logic [10:0] image_height_q;
	logic [10:0] threshold_q;
	mode_t       mode_q;
	pixel_t      edge_color_q;
	pixel_t      bg_color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= 11'd640;
			image_height_q <= 11'd480;
			threshold_q    <= 11'd50;
			mode_q         <= MODE_GRAY;
			edge_color_q   <= 24'hFF0000;
			bg_color_q     <= 24'h0000FF;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[10:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[10:0];
				REG_THRESHOLD:    threshold_q    <= cfg_data[10:0];
				REG_MODE:         mode_q         <= mode_t'(cfg_data[1:0]);
				REG_EDGE_COLOR:   edge_color_q   <= cfg_data;
				REG_BG_COLOR:     bg_color_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// last column and last row after clamping the frame size
	logic [CW-1:0] wl;
	logic [RW-1:0] hl;

	always_comb begin
		if (image_width_q < 11'd2) begin
			wl = CW'(1);
		end else if (32'(image_width_q) > MAX_WIDTH) begin
			wl = CW'(MAX_WIDTH - 1);
		end else begin
			wl = CW'(image_width_q - 11'd1);
		end
		if (image_height_q < 11'd2) begin
			hl = RW'(1);
		end else if (32'(image_height_q) > MAX_HEIGHT) begin
			hl = RW'(MAX_HEIGHT - 1);
		end else begin
			hl = RW'(image_height_q - 11'd1);
		end
	end

	// position counters
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] c_in;
	logic [RW-1:0] r_in;
	logic          in_beat;

	assign c_in    = (col_q > wl) ? wl : col_q;
	assign r_in    = (row_q > hl) ? hl : row_q;
	assign in_beat = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_beat) begin
			if (c_in == wl) begin
				col_q <= '0;
				row_q <= (r_in == hl) ? '0 : r_in + RW'(1);
			end else begin
				col_q <= c_in + CW'(1);
			end
		end
	end

	// line store
	pixel_t up_s1;

	reh_ram #(
		.WIDTH(24),
		.DEPTH(MAX_WIDTH)
	) u_row_store (
		.clk   (clk),
		.we    (in_beat),
		.waddr (c_in),
		.wdata (s_axis_tdata),
		.re    (in_beat),
		.raddr (c_in),
		.rdata (up_s1)
	);

	// stage 1: one pixel with its pending results
	logic          v_s1;
	logic [3:0]    pend_s1;
	pixel_t        cur_s1;
	logic [CW-1:0] c_s1;
	logic [RW-1:0] r_s1;
	pixel_t        left_q;
	pixel_t        upleft_q;
	logic [3:0]    mask_in;

	always_comb begin
		mask_in[RES_DIAG]     = (r_in != '0) && (c_in != '0);
		mask_in[RES_LAST_COL] = (r_in != '0) && (c_in == wl);
		mask_in[RES_LAST_ROW] = (r_in == hl) && (c_in != '0);
		mask_in[RES_CORNER]   = (r_in == hl) && (c_in == wl);
	end

	logic     out_free;
	logic     emit;
	logic     last_sel;
	logic     done_s1;
	res_sel_t sel;
	logic [3:0] pend_rest;

	always_comb begin
		if (pend_s1[RES_DIAG]) begin
			sel = RES_DIAG;
		end else if (pend_s1[RES_LAST_COL]) begin
			sel = RES_LAST_COL;
		end else if (pend_s1[RES_LAST_ROW]) begin
			sel = RES_LAST_ROW;
		end else begin
			sel = RES_CORNER;
		end
	end

	assign pend_rest     = pend_s1 & (pend_s1 - 4'd1);
	assign last_sel      = (pend_rest == '0);
	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign emit          = v_s1 && (pend_s1 != '0) && out_free;
	assign done_s1       = v_s1 && ((pend_s1 == '0) || (emit && last_sel));
	assign s_axis_tready = !v_s1 || done_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			pend_s1  <= '0;
			left_q   <= '0;
			upleft_q <= '0;
		end else begin
			if (done_s1) begin
				left_q   <= cur_s1;
				upleft_q <= up_s1;
			end
			if (in_beat) begin
				v_s1    <= 1'b1;
				pend_s1 <= mask_in;
			end else if (done_s1) begin
				v_s1    <= 1'b0;
				pend_s1 <= '0;
			end else if (emit) begin
				pend_s1 <= pend_rest;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			cur_s1 <= s_axis_tdata;
			c_s1   <= c_in;
			r_s1   <= r_in;
		end
	end

	// gradient and pixel choice for the selected result
	pixel_t        p00, p01, p10, p11, orig;
	logic [CW-1:0] c_res;
	logic [RW-1:0] r_res;
	logic [10:0]   grad;
	logic [7:0]    gray;
	logic          is_edge;
	pixel_t        px;

	always_comb begin
		case (sel)
			RES_DIAG: begin
				p00 = upleft_q; p01 = up_s1; p10 = left_q; p11 = cur_s1;
				orig = upleft_q;
				r_res = r_s1 - RW'(1); c_res = c_s1 - CW'(1);
			end
			RES_LAST_COL: begin
				p00 = up_s1; p01 = up_s1; p10 = cur_s1; p11 = cur_s1;
				orig = up_s1;
				r_res = r_s1 - RW'(1); c_res = c_s1;
			end
			RES_LAST_ROW: begin
				p00 = left_q; p01 = cur_s1; p10 = left_q; p11 = cur_s1;
				orig = left_q;
				r_res = r_s1; c_res = c_s1 - CW'(1);
			end
			default: begin
				// corner pixel: all four taps equal, gradient zero
				p00 = cur_s1; p01 = cur_s1; p10 = cur_s1; p11 = cur_s1;
				orig = cur_s1;
				r_res = r_s1; c_res = c_s1;
			end
		endcase
		grad    = roberts(p00, p01, p10, p11);
		gray    = (grad > 11'd255) ? 8'hFF : grad[7:0];
		is_edge = (grad >= threshold_q);
		case (mode_q)
			MODE_GRAY:      px = {gray, gray, gray};
			MODE_EDGE_ORIG: px = is_edge ? edge_color_q : orig;
			MODE_GRAD_BG:   px = is_edge ? {gray, gray, gray} : bg_color_q;
			default:        px = is_edge ? edge_color_q : bg_color_q;
		endcase
	end

	// output register
	logic [9:0] out_row_q;
	logic [9:0] out_col_q;
	pixel_t     out_px_q;
	logic       out_last_q;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_row_q  <= 10'(r_res);
			out_col_q  <= 10'(c_res);
			out_px_q   <= px;
			out_last_q <= last_sel;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0, out_px_q, out_col_q, out_row_q};
	assign m_axis_tlast  = out_last_q;

	// checks
	a_pend_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_s1 != '0) |-> v_s1)
		else $error("results pending with no pixel held");

	a_empty_takes_input: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && pend_s1 == '0) |-> s_axis_tready)
		else $error("pixel without results blocks input");

	a_last_frees_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_sel && !in_beat) |=> !v_s1)
		else $error("stage held after its last result");

	a_emit_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> m_axis_tvalid)
		else $error("result lost on the way to the output register");

endmodule

// File: hdl/reh_ram.sv
`timescale 1ns / 1ps

module reh_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old word when the same address is written
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: bench/reh_checker.sv
`timescale 1ns / 1ps

module reh_checker
	import reh_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // ch0 [7:0], ch1 [15:8], ch2 [23:16]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [47:0] m_axis_tdata,   // row [9:0], col [19:10], ch0, ch1, ch2, zero pad
	input  logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output int          mismatch_count,
	output int          results_owed
);

	typedef struct {
		logic [9:0] row;
		logic [9:0] col;
		pixel_t     px;
		logic       last;
	} highlight_t;

	highlight_t  highlight_q[$];
	pixel_t      line_buf [MAX_WIDTH];
	pixel_t      left_px;
	pixel_t      upleft_px;
	int          col_pos;
	int          row_pos;
	logic [10:0] width_r;
	logic [10:0] height_r;
	logic [10:0] thresh_r;
	mode_t       mode_r;
	pixel_t      edge_r;
	pixel_t      bg_r;

	function automatic int chan_dist(pixel_t a, pixel_t b);
		int s;
		int d;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			d = int'(a[8*i +: 8]) - int'(b[8*i +: 8]);
			s += (d < 0) ? -d : d;
		end
		return s;
	endfunction

	function automatic int cross_grad(pixel_t tl, pixel_t tr, pixel_t bl, pixel_t br);
		return chan_dist(tl, br) + chan_dist(bl, tr);
	endfunction

	function automatic pixel_t shade(int grad, pixel_t orig);
		logic [7:0] gray;
		pixel_t     gray3;
		logic       is_edge;
		gray = (grad > 255) ? 8'd255 : 8'(grad);
		gray3 = {gray, gray, gray};
		is_edge = (grad >= int'(thresh_r));
		case (mode_r)
			MODE_GRAY:      return gray3;
			MODE_EDGE_ORIG: return is_edge ? edge_r : orig;
			MODE_GRAD_BG:   return is_edge ? gray3 : bg_r;
			default:        return is_edge ? edge_r : bg_r;
		endcase
	endfunction

	task automatic highlight_pixel(pixel_t cur);
		highlight_t res [4];
		int         n;
		int         w;
		int         h;
		int         c;
		int         r;
		pixel_t     up;
		n = 0;
		w = (width_r < 11'd2) ? 2 : (width_r > MAX_WIDTH) ? MAX_WIDTH : int'(width_r);
		h = (height_r < 11'd2) ? 2 : (height_r > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_r);
		// a frame size that shrank under the counters pins them to the last column / row
		if (col_pos > w - 1)
			col_pos = w - 1;
		if (row_pos > h - 1)
			row_pos = h - 1;
		c = col_pos;
		r = row_pos;
		up = line_buf[c];
		if (r >= 1 && c >= 1) begin
			res[n] = '{row: 10'(r - 1), col: 10'(c - 1), last: 1'b0,
				px: shade(cross_grad(upleft_px, up, left_px, cur), upleft_px)};
			n++;
		end
		if (r >= 1 && c == w - 1) begin
			res[n] = '{row: 10'(r - 1), col: 10'(c), last: 1'b0,
				px: shade(cross_grad(up, up, cur, cur), up)};
			n++;
		end
		if (r == h - 1 && c >= 1) begin
			res[n] = '{row: 10'(r), col: 10'(c - 1), last: 1'b0,
				px: shade(cross_grad(left_px, cur, left_px, cur), left_px)};
			n++;
		end
		if (r == h - 1 && c == w - 1) begin
			res[n] = '{row: 10'(r), col: 10'(c), last: 1'b0, px: shade(0, cur)};
			n++;
		end
		for (int i = 0; i < n; i++) begin
			res[i].last = (i == n - 1);
			highlight_q.push_back(res[i]);
		end
		line_buf[c] = cur;
		upleft_px = up;
		left_px = cur;
		if (c == w - 1) begin
			col_pos = 0;
			row_pos = (r == h - 1) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		highlight_t want;
		logic       bad;
		if (!arst_n) begin
			width_r = 11'd640;
			height_r = 11'd480;
			thresh_r = 11'd50;
			mode_r = MODE_GRAY;
			edge_r = 24'hFF0000;
			bg_r = 24'h0000FF;
			left_px = '0;
			upleft_px = '0;
			col_pos = 0;
			row_pos = 0;
			highlight_q.delete();
			mismatch_count <= 0;
			results_owed <= 0;
		end else begin
			bad = 1'b0;
			if (cfg_we) begin
				case (reg_index_t'(cfg_index))
					REG_IMAGE_WIDTH:  width_r = cfg_data[10:0];
					REG_IMAGE_HEIGHT: height_r = cfg_data[10:0];
					REG_THRESHOLD:    thresh_r = cfg_data[10:0];
					REG_MODE:         mode_r = mode_t'(cfg_data[1:0]);
					REG_EDGE_COLOR:   edge_r = cfg_data;
					REG_BG_COLOR:     bg_r = cfg_data;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (highlight_q.size() == 0) begin
					$display("%0t: unexpected result beat, row %0d col %0d pixel %06h", $time,
						m_axis_tdata[9:0], m_axis_tdata[19:10], m_axis_tdata[43:20]);
					bad = 1'b1;
				end else begin
					want = highlight_q.pop_front();
					if (m_axis_tdata[9:0] !== want.row) begin
						$display("%0t: row expected %0d, got %0d", $time,
							want.row, m_axis_tdata[9:0]);
						bad = 1'b1;
					end
					if (m_axis_tdata[19:10] !== want.col) begin
						$display("%0t: col expected %0d, got %0d", $time,
							want.col, m_axis_tdata[19:10]);
						bad = 1'b1;
					end
					if (m_axis_tdata[27:20] !== want.px[7:0]) begin
						$display("%0t: (%0d,%0d) ch0 expected %02h, got %02h", $time,
							want.row, want.col, want.px[7:0], m_axis_tdata[27:20]);
						bad = 1'b1;
					end
					if (m_axis_tdata[35:28] !== want.px[15:8]) begin
						$display("%0t: (%0d,%0d) ch1 expected %02h, got %02h", $time,
							want.row, want.col, want.px[15:8], m_axis_tdata[35:28]);
						bad = 1'b1;
					end
					if (m_axis_tdata[43:36] !== want.px[23:16]) begin
						$display("%0t: (%0d,%0d) ch2 expected %02h, got %02h", $time,
							want.row, want.col, want.px[23:16], m_axis_tdata[43:36]);
						bad = 1'b1;
					end
					if (m_axis_tlast !== want.last) begin
						$display("%0t: (%0d,%0d) tlast expected %0b, got %0b", $time,
							want.row, want.col, want.last, m_axis_tlast);
						bad = 1'b1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				highlight_pixel(s_axis_tdata);
			if (bad)
				mismatch_count <= mismatch_count + 1;
			results_owed <= highlight_q.size();
		end
	end

endmodule

// File: bench/tb_roberts_edge_highlighter_core.sv
`timescale 1ns / 1ps

module tb_roberts_edge_highlighter_core;
	import reh_pkg::*;

	localparam int MAX_WIDTH     = 1024;
	localparam int MAX_HEIGHT    = 1024;
	localparam int HOLD_CYCLES   = 150;
	localparam int DIRECTED_PIX  = 23;
	localparam int RANDOM_PIXELS = 150;

	typedef enum {TEX_NOISE, TEX_SMOOTH, TEX_EXTREME} texture_t;
	typedef enum {READY_ALWAYS, READY_MOSTLY, READY_SELDOM, READY_PERIODIC} ready_style_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;
	int          mismatch_count;
	int          results_owed;

	// sender side frame position, kept to know where a frame ends
	logic [10:0] cfg_width;
	logic [10:0] cfg_height;
	int          pos_col;
	int          pos_row;
	int          burst_left;
	int          pixels_sent;
	bit          steady_sender;
	texture_t    texture;
	pixel_t      last_px;
	logic        hold_req = 1'b0;
	logic        hold_ack = 1'b0;

	roberts_edge_highlighter_core #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	reh_checker #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatch_count(mismatch_count),
		.results_owed(results_owed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int clamp_size(logic [10:0] v, int hi);
		return (v < 11'd2) ? 2 : (v > hi) ? hi : int'(v);
	endfunction

	function automatic pixel_t next_pixel();
		int v;
		pixel_t p;
		case (texture)
			TEX_NOISE: p = pixel_t'($urandom());
			TEX_SMOOTH: begin
				for (int i = 0; i < 3; i++) begin
					v = int'(last_px[8*i +: 8]) + int'($urandom_range(0, 24)) - 12;
					p[8*i +: 8] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
				end
			end
			default: begin
				for (int i = 0; i < 3; i++)
					p[8*i +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
		endcase
		last_px = p;
		return p;
	endfunction

	task automatic send_pixel(pixel_t p);
		int gap;
		int w;
		int h;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = steady_sender ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= p;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pixels_sent++;
		w = clamp_size(cfg_width, MAX_WIDTH);
		h = clamp_size(cfg_height, MAX_HEIGHT);
		if (pos_col > w - 1)
			pos_col = w - 1;
		if (pos_row > h - 1)
			pos_row = h - 1;
		if (pos_col == w - 1) begin
			pos_col = 0;
			pos_row = (pos_row == h - 1) ? 0 : pos_row + 1;
		end else begin
			pos_col++;
		end
	endtask

	task automatic finish_frame();
		do
			send_pixel(next_pixel());
		while (pos_col != 0 || pos_row != 0);
	endtask

	// stop sending and let the block empty, including pixels that produce nothing
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_write(reg_index_t idx, logic [23:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_frame(logic [10:0] w, logic [10:0] h, logic [10:0] thr, mode_t m,
			pixel_t edge_col, pixel_t bg_col);
		cfg_write(REG_IMAGE_WIDTH, 24'(w));
		cfg_write(REG_IMAGE_HEIGHT, 24'(h));
		cfg_write(REG_THRESHOLD, 24'(thr));
		cfg_write(REG_MODE, 24'(m));
		cfg_write(REG_EDGE_COLOR, edge_col);
		cfg_write(REG_BG_COLOR, bg_col);
		cfg_we <= 1'b0;
		cfg_width = w;
		cfg_height = h;
	endtask

	task automatic resize(logic [10:0] w, logic [10:0] h);
		cfg_write(REG_IMAGE_WIDTH, 24'(w));
		cfg_write(REG_IMAGE_HEIGHT, 24'(h));
		cfg_we <= 1'b0;
		cfg_width = w;
		cfg_height = h;
	endtask

	function automatic logic [10:0] random_threshold();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 5)
			return 11'($urandom_range(0, 60));
		else if (pick < 15)
			return 11'($urandom_range(0, 600));
		else if (pick < 18)
			return 11'($urandom_range(1400, 1530));
		return 11'($urandom_range(1531, 2047));
	endfunction

	// receiver: changes its stall pattern now and then, long hold-off on request
	initial begin
		ready_style_t style;
		int cycle;
		m_axis_tready <= 1'b0;
		style = READY_ALWAYS;
		cycle = 0;
		forever begin
			@(posedge clk);
			cycle++;
			if (hold_req != hold_ack) begin
				hold_ack = hold_req;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (cycle % 150 == 0)
					style = ready_style_t'($urandom_range(0, 3));
				case (style)
					READY_ALWAYS:  m_axis_tready <= 1'b1;
					READY_MOSTLY:  m_axis_tready <= ($urandom_range(0, 3) != 0);
					READY_SELDOM:  m_axis_tready <= ($urandom_range(0, 2) == 0);
					default:       m_axis_tready <= ((cycle % 7) >= 3);
				endcase
			end
		end
	end

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		logic [10:0] w;
		logic [10:0] h;
		int          n;
		int          phase_no;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= '0;
		arst_n <= 1'b0;
		cfg_width = 11'd640;
		cfg_height = 11'd480;
		pos_col = 0;
		pos_row = 0;
		burst_left = 0;
		pixels_sent = 0;
		steady_sender = 1'b0;
		texture = TEX_NOISE;
		last_px = '0;
		phase_no = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sizes below two saturate to a 2x2 frame; full-scale gradient saturates the gray
		set_frame(11'd1, 11'd0, 11'd0, MODE_GRAY, 24'hFF0000, 24'h0000FF);
		send_pixel(24'h000000);
		send_pixel(24'h000000);
		send_pixel(24'hFFFFFF);
		send_pixel(24'hFFFFFF);
		settle();

		// stripes give gradient 1530, exactly at the top threshold
		set_frame(11'd3, 11'd3, 11'd1530, MODE_EDGE_ORIG, 24'hFFFFFF, 24'h000000);
		for (int i = 0; i < 9; i++)
			send_pixel((i / 3 == 1) ? 24'hFFFFFF : 24'h000000);
		settle();

		// threshold above the largest gradient: nothing is an edge
		set_frame(11'd2, 11'd3, 11'd2047, MODE_GRAD_BG, 24'h123456, 24'hA5A5A5);
		send_pixel(24'hFF00FF);
		send_pixel(24'h00FF00);
		send_pixel(24'h0F0F0F);
		send_pixel(24'hF0F0F0);
		send_pixel(24'hFFFFFF);
		send_pixel(24'h000000);
		settle();

		// gradients of 0, 1 and 2 around a threshold of 1
		set_frame(11'd0, 11'd1, 11'd1, MODE_EDGE_BG, 24'h00FF00, 24'h5A5A5A);
		send_pixel(24'h010101);
		send_pixel(24'h010101);
		send_pixel(24'h010101);
		send_pixel(24'h010100);
		settle();

		while (pixels_sent < DIRECTED_PIX + RANDOM_PIXELS) begin
			phase_no++;
			w = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 1)) :
				11'($urandom_range(2, 12));
			h = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 1)) :
				11'($urandom_range(2, 7));
			if (phase_no == 2) begin
				w = 11'd16;
				h = 11'd6;
			end
			set_frame(w, h, random_threshold(), mode_t'($urandom_range(0, 3)),
				pixel_t'($urandom()), pixel_t'($urandom()));
			texture = texture_t'($urandom_range(0, 2));
			steady_sender = ($urandom_range(0, 3) == 0);
			if (phase_no == 2) begin
				// output held off while pixels keep coming, so the input must back up
				steady_sender = 1'b1;
				hold_req <= ~hold_req;
				finish_frame();
			end else if ($urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, clamp_size(w, MAX_WIDTH) * clamp_size(h, MAX_HEIGHT) - 1);
				repeat (n) send_pixel(next_pixel());
				settle();
				// width only shrinks mid-frame so every column read was written in the row above
				resize(11'($urandom_range(2, clamp_size(w, MAX_WIDTH))),
					11'($urandom_range(0, 9)));
				finish_frame();
			end else begin
				finish_frame();
			end
			settle();
		end

		// oversize registers saturate to the largest frame; shrinking mid-frame then
		// pins the counters to the new last column and last row
		set_frame(11'd2047, 11'd2047, random_threshold(), mode_t'($urandom_range(0, 3)),
			pixel_t'($urandom()), pixel_t'($urandom()));
		texture = TEX_NOISE;
		repeat (5) send_pixel(next_pixel());
		settle();
		resize(11'd2, 11'd2047);
		texture = TEX_SMOOTH;
		repeat (11) send_pixel(next_pixel());
		settle();
		resize(11'd2, 11'd2);
		finish_frame();
		settle();

		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && results_owed == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
